// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the sample set statistics block.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ssstat_pkg.sv =====
// Types and constants shared by the sample set statistics block.
`default_nettype none

package ssstat_pkg;

   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 9;
   localparam int DIV_W    = 64;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } ssstat_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0] minimum;
      logic [SAMPLE_W-1:0] maximum;
      logic [SAMPLE_W-1:0] std_dev;
      logic [COUNT_W-1:0]  sample_count;
      logic                overflowed;
   } ssstat_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ssstat_div_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ssstat_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ssstat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ssstat_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module ssstat_div
   import ssstat_pkg::*;
#(
   parameter int DIVISOR_W = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output      logic [DIV_W-1:0]     quotient,
   output      ssstat_div_stat_type  stat
);

   localparam int STEP_W = $clog2(DIV_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      // Bring down the next dividend bit and try to subtract the divisor.
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = (trial >= {1'b0, divisor_ff});
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `ASSERT_IMPLIES(a_start_idle, start, !busy_ff, "divider started while busy")
   `ASSERT_NEXT(a_start_busy, start, busy_ff, "divider did not begin after start")
   `ASSERT_IMPLIES(a_done_idle, done_ff, !busy_ff, "divider done while still busy")

endmodule

`default_nettype wire

// ===== hw/rtl/sample_set_statistics.sv =====
// Sample set statistics: mean, minimum, maximum and standard deviation of a stored set.
// While loading, the block takes a new sample in every cycle.
// After the item that closes a set, the result is worked out in order: a divide for the mean,
// one store read per sample, a second divide for the variance and a 32-step square root.
// Reset is synchronous; it empties the set, and the sample store needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module sample_set_statistics
   import ssstat_pkg::*;
#(
   parameter int MAX_SAMPLES = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output      logic           req_stall,
   input  wire ssstat_req_type req_item,
   output      logic           rsp_valid,
   input  wire logic           rsp_stall,
   output      ssstat_rsp_type rsp_item
);

   // The store is addressed by ADDR_W bits; the fill count must also be able to hold
   // MAX_SAMPLES itself, and the running sum must hold MAX_SAMPLES full-scale samples.
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS;

   // Sequencer states.
   localparam logic [2:0] ST_LOAD = 3'd0;  // taking samples
   localparam logic [2:0] ST_MEAN = 3'd1;  // divider works out the mean
   localparam logic [2:0] ST_PASS = 3'd2;  // second pass over the store
   localparam logic [2:0] ST_VAR  = 3'd3;  // divider works out the variance
   localparam logic [2:0] ST_SQRT = 3'd4;  // square root, one result bit per step
   localparam logic [2:0] ST_DONE = 3'd5;  // waiting for the output register

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                   drop_ff, drop_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [DIV_W-1:0]       acc_ff, acc_in;
   logic                   div_start_ff, div_start_in;

   // Second-pass pipeline: store read, absolute deviation, square.
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;
   logic [SAMPLE_BITS-1:0] dev_ff, dev_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;

   // Square root working registers.
   logic [DIV_W-1:0]       rad_ff, rad_in;
   logic [DIV_W-1:0]       root_ff, root_in;
   logic [DIV_W-1:0]       sq_bit_ff, sq_bit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   ssstat_rsp_type         rsp_item_ff, rsp_item_in;

   logic                   req_fire;
   logic [SAMPLE_BITS-1:0] sample_val;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [SAMPLE_BITS-1:0] ram_rd_data;
   logic                   issuing;
   logic [DIV_W:0]         acc_sum;
   logic [DIV_W-1:0]       root_trial;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_quotient;
   ssstat_div_stat_type    div_stat;

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_fire   = req_valid && !req_stall;
   assign sample_val = req_item.sample[SAMPLE_BITS-1:0];

   // A sample is written at the current fill count while the store has room.
   assign ram_wr_en = req_fire && (count_ff < CNT_W'(MAX_SAMPLES));

   // The second pass reads every stored sample once, in order.
   assign issuing   = (state_ff == ST_PASS) && (issue_ff != count_ff);
   assign ram_rd_en = issuing;

   // The divider takes the running sum first and the deviation sum second.
   assign div_dividend = (state_ff == ST_MEAN) ? DIV_W'(sum_ff) : acc_ff;

   // The deviation sum saturates rather than wrapping.
   assign acc_sum    = {1'b0, acc_ff} + (DIV_W + 1)'(sq_ff);
   assign root_trial = root_ff + sq_bit_ff;

   ssstat_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (sample_val),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ssstat_div #(
      .DIVISOR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      drop_in      = drop_ff;
      mean_in      = mean_ff;
      acc_in       = acc_ff;
      div_start_in = 1'b0;
      issue_in     = issue_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      sq_bit_in    = sq_bit_ff;
      rsp_item_in  = rsp_item_ff;
      // The output register empties when its item is taken.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // The deviation pipeline advances on its own once fed.
      v1_in  = issuing;
      v2_in  = v1_ff;
      v3_in  = v2_ff;
      dev_in = (ram_rd_data >= mean_ff) ? (ram_rd_data - mean_ff) : (mean_ff - ram_rd_data);
      sq_in  = SQ_W'(dev_ff) * SQ_W'(dev_ff);
      if (v3_ff) begin
         acc_in = acc_sum[DIV_W] ? '1 : acc_sum[DIV_W-1:0];
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (ram_wr_en) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + SUM_W'(sample_val);
                  if (sample_val < min_ff) begin
                     min_in = sample_val;
                  end
                  if (sample_val > max_ff) begin
                     max_in = sample_val;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_item.last) begin
                  state_in     = ST_MEAN;
                  div_start_in = 1'b1;
               end
            end
         end
         ST_MEAN: begin
            if (div_stat.done) begin
               // The mean never exceeds the largest sample, so it fits a sample.
               mean_in  = div_quotient[SAMPLE_BITS-1:0];
               issue_in = '0;
               acc_in   = '0;
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
            end else if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in     = ST_VAR;
               div_start_in = 1'b1;
            end
         end
         ST_VAR: begin
            if (div_stat.done) begin
               rad_in    = div_quotient;
               root_in   = '0;
               sq_bit_in = DIV_W'(1) << (DIV_W - 2);
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               if (rad_ff >= root_trial) begin
                  rad_in  = rad_ff - root_trial;
                  root_in = (root_ff >> 1) + sq_bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_item_in.mean         = SAMPLE_W'(mean_ff);
               rsp_item_in.minimum      = SAMPLE_W'(min_ff);
               rsp_item_in.maximum      = SAMPLE_W'(max_ff);
               rsp_item_in.std_dev      = root_ff[SAMPLE_W-1:0];
               rsp_item_in.sample_count = COUNT_W'(count_ff);
               rsp_item_in.overflowed   = drop_ff;
               rsp_valid_in             = 1'b1;
               // The set starts afresh; the store keeps its stale contents.
               count_in = '0;
               sum_in   = '0;
               min_in   = '1;
               max_in   = '0;
               drop_in  = 1'b0;
               acc_in   = '0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         drop_ff      <= 1'b0;
         acc_ff       <= '0;
         div_start_ff <= 1'b0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         drop_ff      <= drop_in;
         acc_ff       <= acc_in;
         div_start_ff <= div_start_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff     <= mean_in;
      dev_ff      <= dev_in;
      sq_ff       <= sq_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      sq_bit_ff   <= sq_bit_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `ASSERT_HOLDS(a_count_bound, count_ff <= CNT_W'(MAX_SAMPLES),
      "fill count beyond store capacity")
   `ASSERT_IMPLIES(a_drop_full, drop_ff, count_ff == CNT_W'(MAX_SAMPLES),
      "sample dropped while the store had room")
   `ASSERT_IMPLIES(a_done_sane, state_ff == ST_DONE, (count_ff != '0) && (min_ff <= max_ff),
      "result formed over an empty or inconsistent set")
   `ASSERT_IMPLIES(a_div_free, div_start_ff, !div_stat.busy,
      "divider restarted while busy")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the sample set statistics block, with an in-bench predictor.

module tb;
   import ssstat_pkg::*;

   // The store holds this many samples; anything beyond it in a set is dropped.
   localparam int STORE_DEPTH  = 256;
   // Number of items the random part aims for.
   localparam int ITEM_GOAL    = 1900;
   // Each side idles in roughly this many cycles out of a hundred.
   localparam int IDLE_PERCENT = 32;
   // Window of cycles in which neither side idles at all.
   localparam int QUIET_FROM   = 6000;
   localparam int QUIET_TO     = 11000;
   // The receiver holds off for one long stretch, starting at this cycle, which falls
   // early in the random sets so that it is always reached.
   localparam int HOLD_FROM    = 3000;
   localparam int HOLD_CYCLES  = 3000;
   // Cycles waited after the last expected result has come back.
   localparam int DRAIN_CYCLES = 600;
   // Far beyond the slowest correct run, even with one result per item.
   localparam int RUN_LIMIT    = 30_000_000;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   ssstat_req_type req_item  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   ssstat_rsp_type rsp_item;

   sample_set_statistics u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // Items waiting to be offered, and statistics waiting to come back.
   ssstat_req_type pending_items[$];
   ssstat_rsp_type expected_stats[$];

   // The bench's own copy of the block's set state.
   logic [31:0] shadow_store [STORE_DEPTH];
   logic [39:0] shadow_sum     = '0;
   int          shadow_count   = 0;
   logic [31:0] shadow_min     = '1;
   logic [31:0] shadow_max     = '0;
   logic        shadow_dropped = 1'b0;

   int cycle_count    = 0;
   int items_queued   = 0;
   int items_accepted = 0;
   int sets_closed    = 0;
   int overflow_sets  = 0;
   int largest_set    = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   logic hold_off     = 1'b0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Random idling on either side, except inside the quiet window.
   function automatic logic idle_now(input int cyc);
      if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PERCENT;
   endfunction

   // Truncated square root of a 64-bit value, built one result bit at a time from the top.
   function automatic logic [31:0] floor_root(input logic [63:0] v);
      logic [31:0] r;
      logic [63:0] trial;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = {32'd0, r | (32'd1 << b)};
         if (trial * trial <= v) r = r | (32'd1 << b);
      end
      return r;
   endfunction

   // Takes one accepted item into the shadow state; an item with last set closes the set
   // and queues the statistics the block must give for it.
   task automatic take_sample(input ssstat_req_type it);
      ssstat_rsp_type stats;
      logic [63:0]    mean64;
      logic [63:0]    dev;
      logic [63:0]    sq;
      logic [63:0]    sq_sum;
      logic [63:0]    variance;
      if (shadow_count < STORE_DEPTH) begin
         shadow_store[shadow_count] = it.sample;
         shadow_count++;
         shadow_sum = shadow_sum + it.sample;
         if (it.sample < shadow_min) shadow_min = it.sample;
         if (it.sample > shadow_max) shadow_max = it.sample;
      end else begin
         shadow_dropped = 1'b1;
      end
      if (it.last) begin
         // The count is never zero here, since the closing item is either stored or dropped
         // from a full store; the zero guard only mirrors the defined fallback.
         mean64   = (shadow_count != 0) ? {24'd0, shadow_sum} / shadow_count : '0;
         sq_sum   = '0;
         for (int i = 0; i < shadow_count; i++) begin
            dev = ({32'd0, shadow_store[i]} >= mean64) ? {32'd0, shadow_store[i]} - mean64
                                                       : mean64 - {32'd0, shadow_store[i]};
            sq  = dev * dev;
            // The deviation sum sticks at all ones rather than wrapping.
            if (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) sq_sum = 64'hFFFF_FFFF_FFFF_FFFF;
            else                                        sq_sum = sq_sum + sq;
         end
         variance           = (shadow_count != 0) ? sq_sum / shadow_count : '0;
         stats.mean         = mean64[31:0];
         stats.minimum      = shadow_min;
         stats.maximum      = shadow_max;
         stats.std_dev      = floor_root(variance);
         stats.sample_count = shadow_count[COUNT_W-1:0];
         stats.overflowed   = shadow_dropped;
         expected_stats.push_back(stats);
         sets_closed++;
         if (shadow_dropped) overflow_sets++;
         if (shadow_count > largest_set) largest_set = shadow_count;
         // Everything but the store goes back to its reset value for the next set.
         shadow_sum     = '0;
         shadow_count   = 0;
         shadow_min     = '1;
         shadow_max     = '0;
         shadow_dropped = 1'b0;
      end
   endtask

   // Driver: offers pending items, holds a stalled item steady, and hands every accepted
   // item to the predictor at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            take_sample(req_item);
            items_accepted++;
         end
         if (pending_items.size() != 0 && !idle_now(cycle_count)) begin
            req_item  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side, counted here, so that the block backs up and
   // stalls its input while the driver keeps offering items.
   int hold_left = 0;
   always @(posedge clock) begin
      if (cycle_count == HOLD_FROM) begin
         hold_left <= HOLD_CYCLES;
         hold_off  <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else begin
         hold_left <= 0;
         hold_off  <= 1'b0;
      end
   end

   // Monitor: every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_stats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing expected: mean=%h min=%h max=%h sd=%h n=%0d ovf=%b",
                        rsp_item.mean, rsp_item.minimum, rsp_item.maximum, rsp_item.std_dev,
                        rsp_item.sample_count, rsp_item.overflowed);
         end else begin
            ssstat_rsp_type want;
            want = expected_stats.pop_front();
            if (rsp_item !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch in result %0d:", results_seen);
                  $display("  expected mean=%h min=%h max=%h sd=%h n=%0d ovf=%b",
                           want.mean, want.minimum, want.maximum, want.std_dev,
                           want.sample_count, want.overflowed);
                  $display("  actual   mean=%h min=%h max=%h sd=%h n=%0d ovf=%b",
                           rsp_item.mean, rsp_item.minimum, rsp_item.maximum,
                           rsp_item.std_dev, rsp_item.sample_count, rsp_item.overflowed);
               end
            end
         end
      end
      rsp_stall <= hold_off || idle_now(cycle_count);
   end

   task automatic queue_item(input logic [31:0] s, input logic lst);
      ssstat_req_type it;
      it.sample = s;
      it.last   = lst;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Content styles for random sets: anything at all, only the two extremes, a tight
   // cluster around a random centre, or values that fit in sixteen bits.
   function automatic logic [31:0] pick_value(input int style, input logic [31:0] centre);
      case (style)
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
         2: return centre ^ $urandom_range(0, 255);
         default: return $urandom_range(0, 32'h0000_FFFF);
      endcase
   endfunction

   task automatic queue_set(input int size, input int style);
      logic [31:0] centre;
      centre = $urandom;
      for (int i = 0; i < size; i++) queue_item(pick_value(style, centre), i == size - 1);
   endtask

   initial begin
      int size;
      int roll;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed sets: a lone zero, a lone full-scale value, the two extremes together
      // (the widest spread), two runs of repeated equal values (no spread), two values
      // straddling the midpoint, and a small mixed set.
      queue_item(32'h0000_0000, 1'b1);
      queue_item(32'hFFFF_FFFF, 1'b1);
      queue_item(32'h0000_0000, 1'b0);
      queue_item(32'hFFFF_FFFF, 1'b1);
      repeat (3) queue_item(32'h0001_0000, 1'b0);
      queue_item(32'h0001_0000, 1'b1);
      repeat (2) queue_item(32'hFFFF_FFFF, 1'b0);
      queue_item(32'hFFFF_FFFF, 1'b1);
      queue_item(32'h8000_0000, 1'b0);
      queue_item(32'h7FFF_FFFF, 1'b1);
      queue_item(32'h0000_0001, 1'b0);
      queue_item(32'hAAAA_AAAA, 1'b0);
      queue_item(32'h5555_5555, 1'b0);
      queue_item(32'h0002_8000, 1'b0);
      queue_item(32'hFFFF_0000, 1'b0);
      queue_item(32'h0000_FFFF, 1'b1);

      // A set that fills the store exactly with extremes, which drives the deviation
      // sum into saturation.
      queue_set(STORE_DEPTH, 1);
      // A set that runs past the store, closed by an item that is itself dropped.
      queue_set(STORE_DEPTH + $urandom_range(1, 8), 0);

      // Random sets, mostly short, some medium and the odd one around the store size.
      while (items_queued < ITEM_GOAL) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)       size = $urandom_range(STORE_DEPTH - 6, STORE_DEPTH + 40);
         else if (roll < 20) size = $urandom_range(13, 48);
         else                size = $urandom_range(1, 12);
         queue_set(size, $urandom_range(0, 3));
      end

      // Every queued item must have been taken before the remaining results are awaited.
      while (items_accepted != items_queued) @(posedge clock);
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_stats.size() != 0) mismatches++;

      $display("Sent %0d samples in %0d sets (largest %0d, %0d past the store), %0d results.",
               items_accepted, sets_closed, largest_set, overflow_sets, results_seen);
      $display("%0d mismatched or unexpected results.", mismatches);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Backstop in case the block hangs.
   initial begin
      #RUN_LIMIT;
      $display("timeout with %0d results still expected", expected_stats.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
